// ----- hw/rtl/msamp_pkg.sv -----
// Shared constants, types and helper functions for the Markov symbol sampler.
// No dependencies; every other file of the block imports this package.
package msamp_pkg;

	localparam int MAX_ALPHABET = 4;
	localparam int MAX_ORDER    = 5;
	localparam int TABLE_DEPTH  = 8192;

	localparam int ADDR_W     = $clog2(TABLE_DEPTH);
	localparam int PROB_W     = 16;
	localparam int RND_W      = 16;
	localparam int SYM_W      = 2;
	localparam int ORD_W      = 3;
	localparam int ALPHA_W    = 3;
	localparam int HIST_IDX_W = $clog2(MAX_ORDER);
	// The running sum holds at most MAX_ALPHABET full-scale probabilities.
	localparam int ACC_W      = PROB_W + SYM_W;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ALPHABET_SIZE = 1'b0,
		CFG_MODEL_ORDER   = 1'b1
	} cfg_reg_t;

	typedef enum logic {
		REQ_WRITE = 1'b0,
		REQ_DRAW  = 1'b1
	} req_kind_t;

	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
		logic [PROB_W-1:0] data;
	} tbl_wr_t;

	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
	} tbl_rd_t;

	function automatic logic [ALPHA_W-1:0] clamp_alphabet(input logic [ALPHA_W-1:0] a);
		logic [ALPHA_W-1:0] r;
		r = a;
		if (a < ALPHA_W'(2)) r = ALPHA_W'(2);
		if (a > ALPHA_W'(MAX_ALPHABET)) r = ALPHA_W'(MAX_ALPHABET);
		return r;
	endfunction

	function automatic logic [ORD_W-1:0] clamp_order(input logic [ORD_W-1:0] o);
		logic [ORD_W-1:0] r;
		r = o;
		if (o > ORD_W'(MAX_ORDER)) r = ORD_W'(MAX_ORDER);
		return r;
	endfunction

endpackage

// ----- hw/rtl/msamp_if.sv -----
// Valid/ready channel interfaces for the request and result streams of the sampler.
// Depends on msamp_pkg for the field widths.
interface msamp_req_if;
	import msamp_pkg::*;

	logic              valid;
	logic              ready;
	logic              req_type;
	logic [ADDR_W-1:0] table_index;
	logic [PROB_W-1:0] table_prob;
	logic [RND_W-1:0]  random_value;
	logic              restart;

	modport source (output valid, req_type, table_index, table_prob, random_value, restart,
		input ready);
	modport sink (input valid, req_type, table_index, table_prob, random_value, restart,
		output ready);
endinterface

interface msamp_res_if;
	import msamp_pkg::*;

	logic             valid;
	logic             ready;
	logic [SYM_W-1:0] symbol;
	logic [ORD_W-1:0] order_used;

	modport source (output valid, symbol, order_used, input ready);
	modport sink (input valid, symbol, order_used, output ready);
endinterface

// ----- hw/rtl/msamp_table.sv -----
// Probability table: single-port-write, single-port-read synchronous RAM
// with registered read data. Depends on msamp_pkg.
module msamp_table (
	input  logic                      clk,
	input  msamp_pkg::tbl_wr_t        wr,
	input  msamp_pkg::tbl_rd_t        rd,
	output logic [msamp_pkg::PROB_W-1:0] rd_data
);
	import msamp_pkg::*;

	logic [PROB_W-1:0] mem [TABLE_DEPTH];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
	end

	// Read data holds when no read is issued, so a stalled walk keeps its operand.
	always_ff @(posedge clk) begin
		if (rd.en) begin
			rd_data <= mem[rd.addr];
		end
	end

endmodule

// ----- hw/rtl/markov_symbol_sampler_unit.sv -----
// Markov symbol sampler: draws symbols from a variable-order Markov model held
// in a probability table in on-chip RAM.
//
// Channels: req (valid/ready) carries table writes and draw requests; rsp
// (valid/ready) returns one symbol and the context length per draw. Writes
// give no result. The configuration port (cfg_we, cfg_index, cfg_data) sets the
// alphabet size and the maximum order; write it only while the block is idle.
//
// A write is taken in the idle state and leaves the block idle. A draw first
// builds the row base one context symbol per cycle, then walks the cumulative
// sums with one table read per symbol through the single RAM read port, which
// has registered read data, until the draw is done and the result register is
// loaded. The block takes one draw at a time; it accepts the next transaction
// as soon as the result sits in the output register.
//
// Reset clears the history, position count and configuration (alphabet 4,
// order 0). The table has no reset and must be written before it is read.
// When the receiver stalls, a finished draw waits in the walk state until the
// output register is free; the input then stays not ready.
module markov_symbol_sampler_unit (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [msamp_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [msamp_pkg::CFG_DATA_W-1:0] cfg_data,
	msamp_req_if.sink                        req,
	msamp_res_if.source                      rsp
);
	import msamp_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_BASE = 3'b010,
		ST_WALK = 3'b100
	} state_t;

	state_t              state_q;
	logic [ALPHA_W-1:0]  alpha_cfg_q;
	logic [ORD_W-1:0]    order_cfg_q;
	logic [ORD_W-1:0]    pos_q;
	logic [SYM_W-1:0]    hist_q [MAX_ORDER];
	logic [ORD_W-1:0]    ord_q;
	logic [ORD_W-1:0]    k_q;
	logic [ADDR_W-1:0]   base_q;
	logic [ADDR_W-1:0]   pw_q;
	logic [RND_W-1:0]    rnd_q;
	logic [SYM_W-1:0]    sym_q;
	logic [ACC_W-1:0]    acc_q;
	logic                out_valid_q;
	logic [SYM_W-1:0]    out_sym_q;
	logic [ORD_W-1:0]    out_ord_q;

	logic                req_acc;
	logic                draw_acc;
	logic [ALPHA_W-1:0]  alpha_eff;
	logic [ORD_W-1:0]    pos_start;
	logic [ORD_W-1:0]    ord_lim;
	logic [ORD_W-1:0]    ord_start;
	logic [SYM_W-1:0]    hist_k;
	logic                base_done;
	logic [ACC_W-1:0]    acc_new;
	logic                walk_more;
	logic                out_free;
	logic                finish;
	tbl_wr_t             tbl_wr;
	tbl_rd_t             tbl_rd;
	logic [PROB_W-1:0]   tbl_rd_data;

	msamp_table u_table (
		.clk     (clk),
		.wr      (tbl_wr),
		.rd      (tbl_rd),
		.rd_data (tbl_rd_data)
	);

	assign req.ready = (state_q == ST_IDLE);
	assign req_acc   = req.valid && req.ready;
	assign draw_acc  = req_acc && (req_kind_t'(req.req_type) == REQ_DRAW);

	assign alpha_eff = clamp_alphabet(alpha_cfg_q);
	assign pos_start = req.restart ? '0 : pos_q;
	assign ord_lim   = clamp_order(order_cfg_q);
	assign ord_start = (pos_start < ord_lim) ? pos_start : ord_lim;

	assign hist_k    = hist_q[k_q[HIST_IDX_W-1:0]];
	assign base_done = (k_q == ord_q);

	assign acc_new   = acc_q + ACC_W'(tbl_rd_data);
	assign walk_more = (ACC_W'(rnd_q) > acc_new) && (ALPHA_W'(sym_q) < (alpha_eff - ALPHA_W'(1)));
	assign out_free  = !out_valid_q || rsp.ready;
	assign finish    = (state_q == ST_WALK) && !walk_more && out_free;

	assign tbl_wr.en   = req_acc && (req_kind_t'(req.req_type) == REQ_WRITE);
	assign tbl_wr.addr = req.table_index;
	assign tbl_wr.data = req.table_prob;

	always_comb begin
		tbl_rd.en   = 1'b0;
		tbl_rd.addr = base_q;
		unique case (state_q)
			ST_BASE: begin
				tbl_rd.en = base_done;
			end
			ST_WALK: begin
				tbl_rd.en   = walk_more;
				tbl_rd.addr = base_q + ADDR_W'(ALPHA_W'(sym_q) + ALPHA_W'(1));
			end
			default: begin
				tbl_rd.en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_cfg_q <= ALPHA_W'(4);
			order_cfg_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_ALPHABET_SIZE: alpha_cfg_q <= cfg_data;
				CFG_MODEL_ORDER:   order_cfg_q <= cfg_data;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pos_q   <= '0;
			for (int i = 0; i < MAX_ORDER; i++) begin
				hist_q[i] <= '0;
			end
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (draw_acc) begin
						pos_q   <= pos_start;
						state_q <= ST_BASE;
					end
				end
				ST_BASE: begin
					if (base_done) begin
						state_q <= ST_WALK;
					end
				end
				ST_WALK: begin
					if (finish) begin
						hist_q[0] <= sym_q;
						for (int i = 1; i < MAX_ORDER; i++) begin
							hist_q[i] <= hist_q[i-1];
						end
						if (pos_q < ORD_W'(MAX_ORDER)) begin
							pos_q <= pos_q + ORD_W'(1);
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Row base: pw_q runs through A, A^2, ... while base_q sums A^(k+1) * (1 + h[k]).
	// Both wrap at the table depth, which is a power of two.
	always_ff @(posedge clk) begin
		if (draw_acc) begin
			ord_q  <= ord_start;
			k_q    <= '0;
			base_q <= '0;
			pw_q   <= ADDR_W'(alpha_eff);
			rnd_q  <= req.random_value;
		end else if (state_q == ST_BASE) begin
			if (!base_done) begin
				base_q <= base_q + ADDR_W'(pw_q * (ALPHA_W'(hist_k) + ALPHA_W'(1)));
				pw_q   <= ADDR_W'(pw_q * alpha_eff);
				k_q    <= k_q + ORD_W'(1);
			end else begin
				sym_q <= '0;
				acc_q <= '0;
			end
		end else if ((state_q == ST_WALK) && walk_more) begin
			sym_q <= sym_q + SYM_W'(1);
			acc_q <= acc_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (finish) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			out_sym_q <= sym_q;
			out_ord_q <= ord_q;
		end
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.symbol     = out_sym_q;
	assign rsp.order_used = out_ord_q;

endmodule

// ----- hw/rtl/msamp_checker.sv -----
// Port-level assertions for the Markov symbol sampler and the bind that
// attaches them to markov_symbol_sampler_unit. Depends on msamp_pkg.
module msamp_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          req_valid,
	input logic                          req_ready,
	input logic                          req_type,
	input logic                          rsp_valid,
	input logic                          rsp_ready,
	input logic [msamp_pkg::SYM_W-1:0]   symbol,
	input logic [msamp_pkg::ORD_W-1:0]   order_used
);
	import msamp_pkg::*;

	logic draw_acc;
	logic write_acc;

	assign draw_acc  = req_valid && req_ready && (req_type == REQ_DRAW);
	assign write_acc = req_valid && req_ready && (req_type == REQ_WRITE);

	// A stalled result keeps its transaction intact.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(symbol) && $stable(order_used))
		else $error("result changed while stalled");

	// A draw occupies the block: no new request is taken in the next cycle.
	a_draw_busy: assert property (@(posedge clk) disable iff (!arst_n)
		draw_acc |=> !req_ready)
		else $error("request accepted right after a draw");

	// A table write never produces a result.
	a_write_silent: assert property (@(posedge clk) disable iff (!arst_n)
		write_acc && !rsp_valid |=> !rsp_valid)
		else $error("result appeared after a table write");

	// The reported context length never exceeds the deepest supported order.
	a_order_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> order_used <= ORD_W'(MAX_ORDER))
		else $error("context length out of range");

endmodule

bind markov_symbol_sampler_unit msamp_checker u_msamp_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.req_valid  (req.valid),
	.req_ready  (req.ready),
	.req_type   (req.req_type),
	.rsp_valid  (rsp.valid),
	.rsp_ready  (rsp.ready),
	.symbol     (rsp.symbol),
	.order_used (rsp.order_used)
);
